FILE: rtl/gap_affine_wavefront_aligner_macros.svh
// Assertion macros used by the checker of the wavefront aligner.
// No dependencies; included by the checker file.
`ifndef GAP_AFFINE_WAVEFRONT_ALIGNER_MACROS_SVH
`define GAP_AFFINE_WAVEFRONT_ALIGNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GAWA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GAWA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gawa_pkg.sv
// Types and codes of the gap-affine wavefront aligner.
// No dependencies; used by the top level and the checker.
`default_nettype none

package gawa_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_MISMATCH = 2'd0;
    localparam logic [1:0] REG_GAP_OPEN = 2'd1;
    localparam logic [1:0] REG_GAP_EXT  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BOUND = 2'd1;
    localparam logic [1:0] STATUS_LONG  = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_LEVEL,
        ST_MRD1,
        ST_MRD2,
        ST_MRD3,
        ST_BOUNDS,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_COMP,
        ST_EXT_ISS,
        ST_EXT_CMP,
        ST_WR,
        ST_LVL_END,
        ST_NEXT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/gawa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for every store of the aligner.
`default_nettype none

module gawa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/gap_affine_wavefront_aligner.sv
// Top level of the gap-affine wavefront aligner: loader, level sequencer and stores.
// Depends on gawa_pkg and gawa_ram.
`default_nettype none

// Symbols load one per cycle while busy is low, each in a cycle with start high. When
// the second of both sequences is complete, busy rises and the sequencer walks score
// levels 0..MAX_SCORE. A level's setup is the level step, three metadata reads and the
// bounds step; score zero goes from the level step to its single diagonal, and a level
// with no source from the bounds step to the next level. Each diagonal runs four offset
// reads (the shared match store has one read port, so its three reads run in turn),
// compute and write. A live match offset adds an issue step for the extension check, a
// compare and an issue step per matching symbol pair, and a compare step when extension
// stops on a mismatching pair. The end step and, unless done, the next-level step close
// the level. The result is a single-cycle o_valid strobe; the receiver cannot stall it,
// and busy falls in the same cycle. An overlong sequence gives its result in the cycle
// after the last item, with no busy period. No clearing pass is needed after reset.
module gap_affine_wavefront_aligner
    import gawa_pkg::*;
#(
    parameter int MAX_LEN   = 256,
    parameter int MAX_SCORE = 1023,
    parameter int WINDOW    = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_is_last,
    output logic             o_valid,
    output logic [9:0]       o_align_score,
    output logic [1:0]       o_status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LW    = $clog2(MAX_LEN + 2);
    localparam int SAW   = $clog2(MAX_LEN);
    localparam int OW    = $clog2(MAX_LEN + 1) + 1;
    localparam int KW    = LW + 1;
    localparam int KIW   = $clog2(2 * MAX_LEN + 1);
    localparam int SW    = $clog2(MAX_SCORE + 2);
    localparam int SSW   = SW + 1;
    localparam int SLW   = $clog2(WINDOW);
    localparam int MW    = 2 * KW + SW + 1;
    localparam int OAW   = SLW + KIW;
    localparam int ODEP  = WINDOW * (2 ** KIW);

    localparam logic signed [OW-1:0] NONE = '1;

    t_state r_state, n_state;

    logic [3:0] r_pen_x, r_pen_o, r_pen_e;
    logic [LW-1:0] r_len_a, n_len_a, r_len_b, n_len_b;
    logic [1:0] r_flags, n_flags;
    logic [LW-1:0] r_la, n_la, r_lb, n_lb;
    logic [SW-1:0] r_score, n_score;
    logic [SLW-1:0] r_slot, n_slot;
    logic [2:0] r_pres, n_pres;
    logic signed [KW-1:0] r_src_lo [3];
    logic signed [KW-1:0] n_src_lo [3];
    logic signed [KW-1:0] r_src_hi [3];
    logic signed [KW-1:0] n_src_hi [3];
    logic signed [KW-1:0] r_lo, n_lo, r_hi, n_hi, r_k, n_k;
    logic r_any, n_any, r_done, n_done;
    logic signed [OW-1:0] r_c_moel, n_c_moel, r_c_moeh, n_c_moeh, r_c_mx, n_c_mx;
    logic signed [OW-1:0] r_c_ie, n_c_ie, r_c_de, n_c_de;
    logic signed [OW-1:0] r_ins, n_ins, r_del, n_del, r_h, n_h, r_v, n_v;
    logic r_valid, n_valid;
    logic [9:0] r_res_score, n_res_score;
    logic [1:0] r_res_status, n_res_status;

    // Store ports.
    logic seq_a_we, seq_b_we;
    logic [SAW-1:0] seq_waddr, seq_a_raddr, seq_b_raddr;
    logic [7:0] seq_a_rdata, seq_b_rdata;
    logic meta_we;
    logic [SLW-1:0] meta_waddr, meta_raddr;
    logic [MW-1:0] meta_wdata, meta_rdata;
    logic off_we;
    logic [OAW-1:0] off_waddr, m_raddr, i_raddr, d_raddr;
    logic [OW-1:0] m_rdata, i_rdata, d_rdata;

    logic [4:0] pen_x, pen_e, pen_oe;
    logic [4:0] src_d [3];
    logic signed [SSW-1:0] src_s [3];
    logic [SLW-1:0] src_slot [3];
    logic meta_ok;
    logic [SW-1:0] meta_tag;
    logic signed [KW-1:0] meta_lo, meta_hi;
    logic accept, cfg_wr;
    logic signed [KW-1:0] k_dn, k_up, kend, la_s, lb_s;

    // Offset-store address of diagonal k in a level slot.
    function automatic logic [OAW-1:0] off_addr(input logic [SLW-1:0] slot,
                                                 input logic signed [KW-1:0] k);
        logic signed [KW:0] idx;
        idx = $signed({k[KW-1], k}) + $signed((KW + 1)'(MAX_LEN));
        return {slot, idx[KIW-1:0]};
    endfunction

    // Offset src plus add on diagonal k, kept only inside both sequences.
    function automatic logic signed [OW-1:0] advance(input logic signed [OW-1:0] src,
                                                     input logic add,
                                                     input logic signed [KW-1:0] k,
                                                     input logic [LW-1:0] la,
                                                     input logic [LW-1:0] lb);
        logic signed [OW-1:0] h;
        logic signed [KW:0] v;
        h = src + $signed({{(OW - 1){1'b0}}, add});
        v = $signed((KW + 1)'(h)) - $signed({k[KW-1], k});
        if (src < 0) begin
            return NONE;
        end
        if ($signed((KW + 1)'(h)) > $signed({2'b00, lb})) begin
            return NONE;
        end
        if (v < 0 || v > $signed({2'b00, la})) begin
            return NONE;
        end
        return h;
    endfunction

    function automatic logic signed [OW-1:0] max2(input logic signed [OW-1:0] p,
                                                  input logic signed [OW-1:0] q);
        return (p > q) ? p : q;
    endfunction

    // Offset read from a source level, or none when absent or out of its bounds.
    function automatic logic signed [OW-1:0] masked(input logic pres,
                                                    input logic signed [KW-1:0] lo,
                                                    input logic signed [KW-1:0] hi,
                                                    input logic signed [KW-1:0] k,
                                                    input logic [OW-1:0] data);
        if (pres && k >= lo && k <= hi) begin
            return $signed(data);
        end
        return NONE;
    endfunction

    // Ring slot lying d levels behind slot.
    function automatic logic [SLW-1:0] slot_back(input logic [SLW-1:0] slot,
                                                 input logic [4:0] d);
        logic signed [7:0] t;
        t = $signed({{(8 - SLW){1'b0}}, slot}) - $signed({3'b000, d});
        if (t < 0) begin
            t = t + $signed(8'(WINDOW));
        end
        if (t < 0) begin
            t = t + $signed(8'(WINDOW));
        end
        return t[SLW-1:0];
    endfunction

    // Effective penalties: a zero mismatch or extend penalty counts as one.
    assign pen_x  = (r_pen_x == 4'd0) ? 5'd1 : {1'b0, r_pen_x};
    assign pen_e  = (r_pen_e == 4'd0) ? 5'd1 : {1'b0, r_pen_e};
    assign pen_oe = {1'b0, r_pen_o} + pen_e;
    assign src_d[0] = pen_x;
    assign src_d[1] = pen_oe;
    assign src_d[2] = pen_e;

    // Source levels score-x, score-o-e and score-e with their ring slots.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            src_s[j]    = $signed({1'b0, r_score}) - $signed(SSW'(src_d[j]));
            src_slot[j] = slot_back(r_slot, src_d[j]);
        end
    end

    assign meta_ok  = meta_rdata[0];
    assign meta_tag = meta_rdata[SW:1];
    assign meta_hi  = $signed(meta_rdata[SW+KW:SW+1]);
    assign meta_lo  = $signed(meta_rdata[MW-1:SW+KW+1]);

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign busy   = (r_state != ST_LOAD);
    assign k_dn   = r_k - KW'(1);
    assign k_up   = r_k + KW'(1);
    assign la_s   = $signed({1'b0, r_la});
    assign lb_s   = $signed({1'b0, r_lb});
    assign kend   = lb_s - la_s;

    // Sequence stores.
    assign seq_a_we  = accept && !i_opcode && !r_flags[0] && (r_len_a < LW'(MAX_LEN));
    assign seq_b_we  = accept && i_opcode && !r_flags[1] && (r_len_b < LW'(MAX_LEN));
    assign seq_waddr = i_opcode ? r_len_b[SAW-1:0] : r_len_a[SAW-1:0];
    assign seq_a_raddr = r_v[SAW-1:0];
    assign seq_b_raddr = r_h[SAW-1:0];

    gawa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq_a (
        .i_clk(i_clk), .i_we(seq_a_we), .i_waddr(seq_waddr), .i_wdata(i_symbol),
        .i_raddr(seq_a_raddr), .o_rdata(seq_a_rdata)
    );

    gawa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq_b (
        .i_clk(i_clk), .i_we(seq_b_we), .i_waddr(seq_waddr), .i_wdata(i_symbol),
        .i_raddr(seq_b_raddr), .o_rdata(seq_b_rdata)
    );

    // Level metadata ring: low and high diagonal, score tag, valid mark.
    assign meta_waddr = r_slot;
    assign meta_wdata = {r_lo, r_hi, r_score, (r_state == ST_LVL_END) && r_any};
    assign meta_we    = (r_state == ST_LVL_END) ||
                        ((r_state == ST_BOUNDS) && (r_pres == 3'b000));

    always_comb begin
        unique case (r_state)
            ST_MRD1: meta_raddr = src_slot[1];
            ST_MRD2: meta_raddr = src_slot[2];
            default: meta_raddr = src_slot[0];
        endcase
    end

    gawa_ram #(.WIDTH(MW), .DEPTH(WINDOW)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_waddr), .i_wdata(meta_wdata),
        .i_raddr(meta_raddr), .o_rdata(meta_rdata)
    );

    // Offset stores of the three wavefronts.
    assign off_we    = (r_state == ST_WR);
    assign off_waddr = off_addr(r_slot, r_k);
    assign i_raddr   = off_addr(src_slot[2], k_dn);
    assign d_raddr   = off_addr(src_slot[2], k_up);

    always_comb begin
        unique case (r_state)
            ST_RD1:  m_raddr = off_addr(src_slot[1], k_up);
            ST_RD2:  m_raddr = off_addr(src_slot[0], r_k);
            default: m_raddr = off_addr(src_slot[1], k_dn);
        endcase
    end

    gawa_ram #(.WIDTH(OW), .DEPTH(ODEP)) u_match (
        .i_clk(i_clk), .i_we(off_we), .i_waddr(off_waddr), .i_wdata(r_h),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    gawa_ram #(.WIDTH(OW), .DEPTH(ODEP)) u_insert (
        .i_clk(i_clk), .i_we(off_we), .i_waddr(off_waddr), .i_wdata(r_ins),
        .i_raddr(i_raddr), .o_rdata(i_rdata)
    );

    gawa_ram #(.WIDTH(OW), .DEPTH(ODEP)) u_delete (
        .i_clk(i_clk), .i_we(off_we), .i_waddr(off_waddr), .i_wdata(r_del),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    // Configuration registers and read-back.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= 4'd4;
            r_pen_o <= 4'd6;
            r_pen_e <= 4'd2;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MISMATCH: r_pen_x <= pwdata[3:0];
                REG_GAP_OPEN: r_pen_o <= pwdata[3:0];
                REG_GAP_EXT:  r_pen_e <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MISMATCH: prdata = {28'd0, r_pen_x};
            REG_GAP_OPEN: prdata = {28'd0, r_pen_o};
            REG_GAP_EXT:  prdata = {28'd0, r_pen_e};
            default:      prdata = 32'd0;
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_len_a <= '0;
            r_len_b <= '0;
            r_flags <= 2'b00;
            r_score <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len_a <= n_len_a;
            r_len_b <= n_len_b;
            r_flags <= n_flags;
            r_score <= n_score;
            r_valid <= n_valid;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_la         <= n_la;
        r_lb         <= n_lb;
        r_slot       <= n_slot;
        r_pres       <= n_pres;
        r_src_lo     <= n_src_lo;
        r_src_hi     <= n_src_hi;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_k          <= n_k;
        r_any        <= n_any;
        r_done       <= n_done;
        r_c_moel     <= n_c_moel;
        r_c_moeh     <= n_c_moeh;
        r_c_mx       <= n_c_mx;
        r_c_ie       <= n_c_ie;
        r_c_de       <= n_c_de;
        r_ins        <= n_ins;
        r_del        <= n_del;
        r_h          <= n_h;
        r_v          <= n_v;
        r_res_score  <= n_res_score;
        r_res_status <= n_res_status;
    end

    // Next state: loading, level setup, per-diagonal build and extension.
    always_comb begin
        logic [LW-1:0] len;
        logic [1:0] flags;
        logic have;
        logic signed [KW-1:0] lo, hi;
        logic signed [OW-1:0] ins, del, mat;
        logic signed [KW:0] v;

        n_state      = r_state;
        n_len_a      = r_len_a;
        n_len_b      = r_len_b;
        n_flags      = r_flags;
        n_la         = r_la;
        n_lb         = r_lb;
        n_score      = r_score;
        n_slot       = r_slot;
        n_pres       = r_pres;
        n_src_lo     = r_src_lo;
        n_src_hi     = r_src_hi;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_k          = r_k;
        n_any        = r_any;
        n_done       = r_done;
        n_c_moel     = r_c_moel;
        n_c_moeh     = r_c_moeh;
        n_c_mx       = r_c_mx;
        n_c_ie       = r_c_ie;
        n_c_de       = r_c_de;
        n_ins        = r_ins;
        n_del        = r_del;
        n_h          = r_h;
        n_v          = r_v;
        n_valid      = 1'b0;
        n_res_score  = r_res_score;
        n_res_status = r_res_status;
        len          = i_opcode ? r_len_b : r_len_a;
        flags        = r_flags;
        have         = 1'b0;
        lo           = '0;
        hi           = '0;
        ins          = NONE;
        del          = NONE;
        mat          = NONE;
        v            = '0;

        unique case (r_state)
            ST_LOAD: begin
                if (accept && !r_flags[i_opcode]) begin
                    if (len < LW'(MAX_LEN)) begin
                        len = len + LW'(1);
                    end else begin
                        len = LW'(MAX_LEN + 1);
                    end
                    if (i_is_last) begin
                        flags[i_opcode] = 1'b1;
                    end
                    n_flags = flags;
                    if (i_opcode) begin
                        n_len_b = len;
                    end else begin
                        n_len_a = len;
                    end
                    if (flags == 2'b11) begin
                        n_la    = i_opcode ? r_len_a : len;
                        n_lb    = i_opcode ? len : r_len_b;
                        n_len_a = '0;
                        n_len_b = '0;
                        n_flags = 2'b00;
                        if (n_la > LW'(MAX_LEN) || n_lb > LW'(MAX_LEN)) begin
                            n_valid      = 1'b1;
                            n_res_score  = 10'd0;
                            n_res_status = STATUS_LONG;
                        end else begin
                            n_score = '0;
                            n_slot  = '0;
                            n_state = ST_LEVEL;
                        end
                    end
                end
            end
            ST_LEVEL: begin
                n_any  = 1'b0;
                n_done = 1'b0;
                if (r_score == '0) begin
                    n_pres  = 3'b000;
                    n_lo    = '0;
                    n_hi    = '0;
                    n_k     = '0;
                    n_state = ST_RD0;
                end else begin
                    n_state = ST_MRD1;
                end
            end
            ST_MRD1, ST_MRD2, ST_MRD3: begin
                for (int j = 0; j < 3; j++) begin
                    if ((j == 0 && r_state == ST_MRD1) || (j == 1 && r_state == ST_MRD2) ||
                        (j == 2 && r_state == ST_MRD3)) begin
                        n_pres[j]   = (src_s[j] >= 0) && (src_slot[j] != r_slot) &&
                                      meta_ok && (meta_tag == src_s[j][SW-1:0]);
                        n_src_lo[j] = meta_lo;
                        n_src_hi[j] = meta_hi;
                    end
                end
                unique case (r_state)
                    ST_MRD1: n_state = ST_MRD2;
                    ST_MRD2: n_state = ST_MRD3;
                    default: n_state = ST_BOUNDS;
                endcase
            end
            ST_BOUNDS: begin
                for (int j = 0; j < 3; j++) begin
                    if (r_pres[j]) begin
                        if (!have || r_src_lo[j] < lo) begin
                            lo = r_src_lo[j];
                        end
                        if (!have || r_src_hi[j] > hi) begin
                            hi = r_src_hi[j];
                        end
                        have = 1'b1;
                    end
                end
                lo = lo - KW'(1);
                hi = hi + KW'(1);
                if (lo < -la_s) begin
                    lo = -la_s;
                end
                if (hi > lb_s) begin
                    hi = lb_s;
                end
                n_lo = lo;
                n_hi = hi;
                n_k  = lo;
                // A level with no source is marked absent in the metadata write.
                n_state = have ? ST_RD0 : ST_NEXT;
            end
            ST_RD0: begin
                n_state = ST_RD1;
            end
            ST_RD1: begin
                n_c_moel = masked(r_pres[1], r_src_lo[1], r_src_hi[1], k_dn, m_rdata);
                n_c_ie   = masked(r_pres[2], r_src_lo[2], r_src_hi[2], k_dn, i_rdata);
                n_c_de   = masked(r_pres[2], r_src_lo[2], r_src_hi[2], k_up, d_rdata);
                n_state  = ST_RD2;
            end
            ST_RD2: begin
                n_c_moeh = masked(r_pres[1], r_src_lo[1], r_src_hi[1], k_up, m_rdata);
                n_state  = ST_RD3;
            end
            ST_RD3: begin
                n_c_mx  = masked(r_pres[0], r_src_lo[0], r_src_hi[0], r_k, m_rdata);
                n_state = ST_COMP;
            end
            ST_COMP: begin
                ins = max2(advance(r_c_moel, 1'b1, r_k, r_la, r_lb),
                           advance(r_c_ie, 1'b1, r_k, r_la, r_lb));
                del = max2(advance(r_c_moeh, 1'b0, r_k, r_la, r_lb),
                           advance(r_c_de, 1'b0, r_k, r_la, r_lb));
                if (r_score == '0) begin
                    mat = '0;
                end else begin
                    mat = max2(max2(ins, del), advance(r_c_mx, 1'b1, r_k, r_la, r_lb));
                end
                v     = $signed((KW + 1)'(mat)) - $signed({r_k[KW-1], r_k});
                n_ins = ins;
                n_del = del;
                n_h   = mat;
                n_v   = v[OW-1:0];
                if (ins >= 0 || del >= 0 || mat >= 0) begin
                    n_any = 1'b1;
                end
                n_state = (mat >= 0) ? ST_EXT_ISS : ST_WR;
            end
            ST_EXT_ISS: begin
                // The sequence reads for the next pair go out in this cycle.
                if ($signed((KW + 1)'(r_v)) < $signed({1'b0, la_s}) &&
                    $signed((KW + 1)'(r_h)) < $signed({1'b0, lb_s})) begin
                    n_state = ST_EXT_CMP;
                end else begin
                    n_state = ST_WR;
                end
            end
            ST_EXT_CMP: begin
                if (seq_a_rdata == seq_b_rdata) begin
                    n_v     = r_v + OW'(1);
                    n_h     = r_h + OW'(1);
                    n_state = ST_EXT_ISS;
                end else begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                if (r_k == kend && $signed((KW + 1)'(r_h)) >= $signed({1'b0, lb_s})) begin
                    n_done = 1'b1;
                end
                if (r_k == r_hi) begin
                    n_state = ST_LVL_END;
                end else begin
                    n_k     = k_up;
                    n_state = ST_RD0;
                end
            end
            ST_LVL_END: begin
                if (r_done) begin
                    n_valid      = 1'b1;
                    n_res_score  = 10'(r_score);
                    n_res_status = STATUS_OK;
                    n_state      = ST_LOAD;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_score == SW'(MAX_SCORE)) begin
                    n_valid      = 1'b1;
                    n_res_score  = 10'd0;
                    n_res_status = STATUS_BOUND;
                    n_state      = ST_LOAD;
                end else begin
                    n_score = r_score + SW'(1);
                    n_slot  = (r_slot == SLW'(WINDOW - 1)) ? '0 : r_slot + SLW'(1);
                    n_state = ST_LEVEL;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign o_valid       = r_valid;
    assign o_align_score = r_res_score;
    assign o_status      = r_res_status;

endmodule

`default_nettype wire

FILE: rtl/gawa_checker.sv
// Port-level checker of the wavefront aligner and its bind to the top level.
// Depends on gawa_pkg and gap_affine_wavefront_aligner_macros.svh.
`default_nettype none
`include "gap_affine_wavefront_aligner_macros.svh"

module gawa_port_checker
    import gawa_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [9:0]  o_align_score,
    input wire logic [1:0]  o_status
);

    // No two results come in a row.
    `GAWA_ASSERT_NXT(a_single_result, i_clk, i_rst_n, o_valid, !o_valid, "two results in a row")

    // A failed job reports a zero score and a known status.
    `GAWA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_valid && o_status != STATUS_OK, o_align_score == 10'd0 && o_status <= STATUS_LONG, "bad failure result")

    // An alignment run always closes with its result strobe.
    `GAWA_ASSERT_IMP(a_run_ends, i_clk, i_rst_n, $fell(busy), o_valid, "run ended without result")

    // No result appears while a run is in progress.
    `GAWA_ASSERT_IMP(a_quiet_busy, i_clk, i_rst_n, busy, !o_valid, "result during run")

endmodule

bind gap_affine_wavefront_aligner gawa_port_checker u_gawa_checker (.*);

`default_nettype wire
